[sv/assert_macros.svh]
// Assertion macros used by the ramp generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

[sv/ddlr_pkg.sv]
// Types and constants of the dual DAC linear ramp generator.
package ddlr_pkg;

  localparam int unsigned DacBitsDef = 12;
  localparam int unsigned ActW       = 2;
  localparam int unsigned TgtW       = 16;
  localparam int unsigned TickW      = 16;

  typedef enum logic [ActW-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_SET   = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

endpackage

[sv/ddlr_if.sv]
// Handshake channels of the ramp generator: command beats in, status beats out.
interface ddlr_in_if;
  import ddlr_pkg::*;

  logic             valid;
  logic             ready;
  logic [ActW-1:0]  action;
  logic [TgtW-1:0]  target_ch1;
  logic [TgtW-1:0]  target_ch2;
  logic [TickW-1:0] ticks_ch1;
  logic [TickW-1:0] ticks_ch2;

  modport source (
    output valid, action, target_ch1, target_ch2, ticks_ch1, ticks_ch2,
    input  ready
  );
  modport sink (
    input  valid, action, target_ch1, target_ch2, ticks_ch1, ticks_ch2,
    output ready
  );
endinterface

interface ddlr_out_if #(
  parameter int unsigned DAC_BITS = ddlr_pkg::DacBitsDef
);
  logic                valid;
  logic                ready;
  logic [DAC_BITS-1:0] dac_ch1;
  logic [DAC_BITS-1:0] dac_ch2;
  logic                done_ch1;
  logic                done_ch2;
  logic                ticking;

  modport source (
    output valid, dac_ch1, dac_ch2, done_ch1, done_ch2, ticking,
    input  ready
  );
  modport sink (
    input  valid, dac_ch1, dac_ch2, done_ch1, done_ch2, ticking,
    output ready
  );
endinterface

[sv/dual_dac_linear_ramp.sv]
// Two-channel DAC ramp generator: direct loads and linear ramps toward targets.
//
// Usage:
//   in_i carries one command per beat: a ramp tick, a ramp start with a
//   target and tick count per channel, or a direct load of both outputs.
//   Targets saturate at full scale; a tick count of zero counts as one.
//   out_o returns one status beat per command: both output codes, the two
//   done flags and whether ticks are acted on, as left by that command.
// Timing:
//   Tick, load and unused commands: status beat in the cycle after acceptance.
//   Ramp start: the command runs through ST_DIV and then ST_FIN to the status
//   beat. The step is found by a bit-serial restoring divider per channel,
//   one quotient bit per cycle. A new command is taken only while the
//   divider is idle.
// Reset:
//   Outputs, positions, targets and steps clear to zero, both channels
//   read as done and ticking is off.
// Stall:
//   The status register holds while out_o.ready is low; a new command is
//   taken in the cycle the pending beat leaves, and a finished division
//   waits in place until the status register is free.
`include "assert_macros.svh"

module dual_dac_linear_ramp #(
  parameter int unsigned DAC_BITS = ddlr_pkg::DacBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  ddlr_in_if.sink    in_i,
  ddlr_out_if.source out_o
);
  import ddlr_pkg::*;

  localparam int unsigned SW   = DAC_BITS + 1;
  localparam int unsigned AW   = DAC_BITS + 2;
  localparam int unsigned CntW = (DAC_BITS > 1) ? $clog2(DAC_BITS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(DAC_BITS - 1);
  localparam logic [TgtW-1:0] CodeMax = TgtW'((1 << DAC_BITS) - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DAC_BITS-1:0]  out_q  [2];
  logic [DAC_BITS-1:0]  out_d  [2];
  logic [DAC_BITS-1:0]  pos_q  [2];
  logic [DAC_BITS-1:0]  pos_d  [2];
  logic [DAC_BITS-1:0]  goal_q [2];
  logic [DAC_BITS-1:0]  goal_d [2];
  logic signed [SW-1:0] step_q [2];
  logic signed [SW-1:0] step_d [2];
  logic [1:0]           fin_q, fin_d;
  logic                 timer_q, timer_d;
  logic                 ovalid_q, ovalid_d;
  logic [DAC_BITS-1:0]  res_dac_q [2];
  logic [DAC_BITS-1:0]  res_dac_d [2];
  logic [1:0]           res_fin_q, res_fin_d;
  logic                 res_tmr_q, res_tmr_d;

  logic [DAC_BITS-1:0]  sgoal_q [2];
  logic [DAC_BITS-1:0]  dvd_q   [2];
  logic [DAC_BITS-1:0]  quo_q   [2];
  logic [TickW-1:0]     dvs_q   [2];
  logic [TickW-1:0]     rem_q   [2];
  logic [1:0]           neg_q, zero_q;

  logic [TgtW-1:0]      tgt    [2];
  logic [TickW-1:0]     tks    [2];
  logic [DAC_BITS-1:0]  sat    [2];
  logic [DAC_BITS-1:0]  mag    [2];
  logic [TickW:0]       rem_sh [2];
  logic                 qbit   [2];
  logic [TickW-1:0]     rem_nx [2];
  logic [DAC_BITS-1:0]  qmag   [2];
  logic signed [SW-1:0] step_nw [2];
  logic signed [AW-1:0] sum    [2];
  logic [1:0]           hit;
  logic [DAC_BITS-1:0]  tpos   [2];
  logic [1:0]           tfin;
  logic                 accept, out_free;

  assign tgt[0] = in_i.target_ch1;
  assign tgt[1] = in_i.target_ch2;
  assign tks[0] = in_i.ticks_ch1;
  assign tks[1] = in_i.ticks_ch2;

  assign out_free   = !ovalid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sat[i] = (tgt[i] > CodeMax) ? CodeMax[DAC_BITS-1:0] : tgt[i][DAC_BITS-1:0];
      mag[i] = (sat[i] > out_q[i]) ? (sat[i] - out_q[i]) : (out_q[i] - sat[i]);

      rem_sh[i] = {rem_q[i], dvd_q[i][DAC_BITS-1]};
      qbit[i]   = (rem_sh[i] >= {1'b0, dvs_q[i]});
      rem_nx[i] = qbit[i] ? TickW'(rem_sh[i] - {1'b0, dvs_q[i]}) : rem_sh[i][TickW-1:0];

      qmag[i]    = (quo_q[i] == '0) ? DAC_BITS'(1) : quo_q[i];
      step_nw[i] = neg_q[i] ? -$signed({1'b0, qmag[i]}) : $signed({1'b0, qmag[i]});

      sum[i]  = $signed({2'b00, pos_q[i]}) + $signed({step_q[i][SW-1], step_q[i]});
      hit[i]  = step_q[i][SW-1] ? (sum[i] <= $signed({2'b00, goal_q[i]}))
                                : (sum[i] >= $signed({2'b00, goal_q[i]}));
      tpos[i] = hit[i] ? goal_q[i] : sum[i][DAC_BITS-1:0];
      tfin[i] = fin_q[i] || hit[i];
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    out_d     = out_q;
    pos_d     = pos_q;
    goal_d    = goal_q;
    step_d    = step_q;
    fin_d     = fin_q;
    timer_d   = timer_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    res_dac_d = res_dac_q;
    res_fin_d = res_fin_q;
    res_tmr_d = res_tmr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (action_e'(in_i.action))
            ACT_TICK: begin
              if (timer_q) begin
                for (int i = 0; i < 2; i++) begin
                  if (!fin_q[i]) begin
                    pos_d[i] = tpos[i];
                    out_d[i] = tpos[i];
                  end
                end
                fin_d   = tfin;
                timer_d = !(tfin[0] && tfin[1]);
              end
            end
            ACT_START: begin
              cnt_d   = '0;
              state_d = ST_DIV;
            end
            ACT_SET: begin
              out_d = sat;
            end
            ACT_NONE: begin
            end
          endcase
          if (action_e'(in_i.action) != ACT_START) begin
            ovalid_d  = 1'b1;
            res_dac_d = out_d;
            res_fin_d = fin_d;
            res_tmr_d = timer_d;
          end
        end
      end
      ST_DIV: begin
        if (cnt_q == CntLast) begin
          cnt_d   = '0;
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          for (int i = 0; i < 2; i++) begin
            goal_d[i] = sgoal_q[i];
            pos_d[i]  = out_q[i];
            step_d[i] = step_nw[i];
          end
          fin_d     = zero_q;
          timer_d   = 1'b1;
          ovalid_d  = 1'b1;
          res_dac_d = out_q;
          res_fin_d = zero_q;
          res_tmr_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_q     <= '{default: '0};
      pos_q     <= '{default: '0};
      goal_q    <= '{default: '0};
      step_q    <= '{default: '0};
      fin_q     <= 2'b11;
      timer_q   <= 1'b0;
      ovalid_q  <= 1'b0;
      res_dac_q <= '{default: '0};
      res_fin_q <= 2'b11;
      res_tmr_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_q     <= out_d;
      pos_q     <= pos_d;
      goal_q    <= goal_d;
      step_q    <= step_d;
      fin_q     <= fin_d;
      timer_q   <= timer_d;
      ovalid_q  <= ovalid_d;
      res_dac_q <= res_dac_d;
      res_fin_q <= res_fin_d;
      res_tmr_q <= res_tmr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 2; i++) begin
      if (accept && (action_e'(in_i.action) == ACT_START)) begin
        sgoal_q[i] <= sat[i];
        dvd_q[i]   <= mag[i];
        quo_q[i]   <= '0;
        rem_q[i]   <= '0;
        dvs_q[i]   <= (tks[i] == '0) ? TickW'(1) : tks[i];
        neg_q[i]   <= (sat[i] <= out_q[i]);
        zero_q[i]  <= (sat[i] == out_q[i]);
      end else if (state_q == ST_DIV) begin
        rem_q[i] <= rem_nx[i];
        dvd_q[i] <= {dvd_q[i][DAC_BITS-2:0], 1'b0};
        quo_q[i] <= {quo_q[i][DAC_BITS-2:0], qbit[i]};
      end
    end
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.dac_ch1  = res_dac_q[0];
  assign out_o.dac_ch2  = res_dac_q[1];
  assign out_o.done_ch1 = res_fin_q[0];
  assign out_o.done_ch2 = res_fin_q[1];
  assign out_o.ticking  = res_tmr_q;

  `ASSERT_CLK(a_idle_timer_fin, clk_i, rst_ni, !timer_q |-> (fin_q[0] && fin_q[1]),
              "ticking off with a channel unfinished")
  `ASSERT_NEVER(a_busy_ready, clk_i, rst_ni, (state_q != ST_IDLE) && in_i.ready,
                "command taken during division")
  `ASSERT_NEVER(a_cnt_idle, clk_i, rst_ni, (state_q != ST_DIV) && (cnt_q != '0),
                "bit counter live outside division")
  `ASSERT_NEVER(a_step_live, clk_i, rst_ni,
                (!fin_q[0] && step_q[0] == '0) || (!fin_q[1] && step_q[1] == '0),
                "zero step on unfinished channel")

endmodule

[tb/sv/ramp_status_checker.sv]
// Status checker: predicts every status beat of the ramp generator and compares it.
`timescale 1ns / 1ps

module ramp_status_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ddlr_in_if   cmd,
  ddlr_out_if  sts,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   checked_o,
  output int   reached_o
);
  import ddlr_pkg::*;

  localparam logic [DacBitsDef-1:0] FullScale = '1;
  localparam int unsigned ReportCap = 30;

  typedef struct packed {
    logic [DacBitsDef-1:0] dac_ch1;
    logic [DacBitsDef-1:0] dac_ch2;
    logic                  done_ch1;
    logic                  done_ch2;
    logic                  ticking;
  } status_t;

  typedef struct {
    logic [DacBitsDef-1:0] code;
    logic [DacBitsDef-1:0] goal;
    int                    pos;
    int                    step;
    bit                    fin;
  } ramp_chan_t;

  ramp_chan_t chan_st [2];
  bit         tick_en;
  status_t    status_q [$];
  int         fail_cnt = 0;
  int         pending  = 0;
  int         checked  = 0;
  int         reached  = 0;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending;
  assign checked_o  = checked;
  assign reached_o  = reached;

  function automatic logic [DacBitsDef-1:0] clip_code(logic [TgtW-1:0] v);
    return (v > FullScale) ? FullScale : v[DacBitsDef-1:0];
  endfunction

  function automatic void launch_ramp(int idx, logic [TgtW-1:0] target,
                                      logic [TickW-1:0] ticks);
    int span;
    int diff;
    span = (ticks == '0) ? 1 : int'(ticks);
    chan_st[idx].goal = clip_code(target);
    chan_st[idx].pos  = int'(chan_st[idx].code);
    diff = int'(chan_st[idx].goal) - chan_st[idx].pos;
    chan_st[idx].step = diff / span;
    if (chan_st[idx].step == 0) chan_st[idx].step = (diff > 0) ? 1 : -1;
    chan_st[idx].fin = (diff == 0);
  endfunction

  function automatic void advance_chan(int idx);
    int nxt;
    int goal;
    if (chan_st[idx].fin) return;
    goal = int'(chan_st[idx].goal);
    nxt  = chan_st[idx].pos + chan_st[idx].step;
    if ((chan_st[idx].step > 0 && nxt >= goal) || (chan_st[idx].step <= 0 && nxt <= goal)) begin
      nxt = goal;
      chan_st[idx].fin = 1'b1;
      reached++;
    end
    chan_st[idx].pos  = nxt;
    chan_st[idx].code = nxt[DacBitsDef-1:0];
  endfunction

  function automatic status_t apply_command(action_e act,
                                            logic [TgtW-1:0] t1, logic [TgtW-1:0] t2,
                                            logic [TickW-1:0] k1, logic [TickW-1:0] k2);
    case (act)
      ACT_TICK: begin
        if (tick_en) begin
          advance_chan(0);
          advance_chan(1);
          if (chan_st[0].fin && chan_st[1].fin) tick_en = 1'b0;
        end
      end
      ACT_START: begin
        launch_ramp(0, t1, k1);
        launch_ramp(1, t2, k2);
        tick_en = 1'b1;
      end
      ACT_SET: begin
        chan_st[0].code = clip_code(t1);
        chan_st[1].code = clip_code(t2);
      end
      default: ;
    endcase
    return '{dac_ch1: chan_st[0].code, dac_ch2: chan_st[1].code,
             done_ch1: chan_st[0].fin, done_ch2: chan_st[1].fin, ticking: tick_en};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (fail_cnt < ReportCap)
      $display("%0t ns: status beat %0d, %s: got %0d, want %0d", $time, checked, what,
               got, want);
    fail_cnt++;
  endtask

  task automatic compare_status();
    status_t want;
    if (status_q.size() == 0) begin
      report_mismatch("beat with no command behind it", 1, 0);
      return;
    end
    want = status_q.pop_front();
    checked++;
    if (sts.dac_ch1 !== want.dac_ch1) report_mismatch("dac_ch1", sts.dac_ch1, want.dac_ch1);
    if (sts.dac_ch2 !== want.dac_ch2) report_mismatch("dac_ch2", sts.dac_ch2, want.dac_ch2);
    if (sts.done_ch1 !== want.done_ch1)
      report_mismatch("done_ch1", sts.done_ch1, want.done_ch1);
    if (sts.done_ch2 !== want.done_ch2)
      report_mismatch("done_ch2", sts.done_ch2, want.done_ch2);
    if (sts.ticking !== want.ticking) report_mismatch("ticking", sts.ticking, want.ticking);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (chan_st[i]) chan_st[i] = '{code: '0, goal: '0, pos: 0, step: 0, fin: 1'b1};
      tick_en = 1'b0;
      status_q.delete();
      pending = 0;
    end else begin
      if (sts.valid === 1'b1 && sts.ready === 1'b1) compare_status();
      if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
        status_q.push_back(apply_command(action_e'(cmd.action), cmd.target_ch1,
                                         cmd.target_ch2, cmd.ticks_ch1, cmd.ticks_ch2));
      pending = status_q.size();
    end
  end

endmodule

[tb/sv/dual_dac_linear_ramp_tb.sv]
// Top of the ramp generator bench: clock, reset, command beats, status stalls, verdict.
`timescale 1ns / 1ps

module dual_dac_linear_ramp_tb;
  import ddlr_pkg::*;

  localparam int unsigned CmdTarget  = 1450;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned FullScale  = (1 << DacBitsDef) - 1;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  int       cycles = 0;
  int       burst_left = 0;
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       sent = 0;
  int       n_start = 0;
  int       n_tick = 0;
  int       n_set = 0;
  int       n_none = 0;
  int       fail_cnt;
  int       pending;
  int       checked;
  int       reached;

  ddlr_in_if cmd_if ();
  ddlr_out_if #(.DAC_BITS(DacBitsDef)) sts_if ();

  dual_dac_linear_ramp #(.DAC_BITS(DacBitsDef)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (sts_if)
  );

  ramp_status_checker status_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd        (cmd_if),
    .sts        (sts_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked),
    .reached_o  (reached)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Run stopped after %0d cycles, %0d status beats outstanding.", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(8, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   sts_if.ready <= 1'b1;
      RX_COIN:   sts_if.ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: sts_if.ready <= ($urandom_range(0, 5) == 0);
      default:   sts_if.ready <= (cycles % 4 != 0);
    endcase
  end

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    cmd_if.valid <= 1'b0;
    repeat (gap) @(negedge clk_i);
  endtask

  task automatic send_cmd(action_e act, logic [TgtW-1:0] t1, logic [TgtW-1:0] t2,
                          logic [TickW-1:0] k1, logic [TickW-1:0] k2);
    pace();
    cmd_if.valid      <= 1'b1;
    cmd_if.action     <= act;
    cmd_if.target_ch1 <= t1;
    cmd_if.target_ch2 <= t2;
    cmd_if.ticks_ch1  <= k1;
    cmd_if.ticks_ch2  <= k2;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    @(negedge clk_i);
    sent++;
    case (act)
      ACT_TICK:  n_tick++;
      ACT_START: n_start++;
      ACT_SET:   n_set++;
      default:   n_none++;
    endcase
  endtask

  function automatic logic [TgtW-1:0] pick_target();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TgtW'(FullScale);
      2, 3:    return TgtW'($urandom);
      default: return TgtW'($urandom_range(0, FullScale));
    endcase
  endfunction

  function automatic logic [TickW-1:0] pick_ticks();
    case ($urandom_range(0, 9))
      0:       return TickW'($urandom);
      1, 2:    return TickW'($urandom_range(13, 64));
      default: return TickW'($urandom_range(0, 12));
    endcase
  endfunction

  task automatic send_noise();
    send_cmd(action_e'($urandom_range(0, 3)), TgtW'($urandom), TgtW'($urandom),
             TickW'($urandom), TickW'($urandom));
  endtask

  task automatic send_tick();
    send_cmd(ACT_TICK, TgtW'($urandom), TgtW'($urandom), TickW'($urandom), TickW'($urandom));
  endtask

  task automatic run_ramp();
    logic [TickW-1:0] k1;
    logic [TickW-1:0] k2;
    int span;
    if ($urandom_range(0, 2) == 0)
      send_cmd(ACT_SET, pick_target(), pick_target(), TickW'($urandom), TickW'($urandom));
    k1 = pick_ticks();
    k2 = pick_ticks();
    send_cmd(ACT_START, pick_target(), pick_target(), k1, k2);
    span = (k1 > k2) ? int'(k1) : int'(k2);
    if (span > 40) span = 40;
    repeat ($urandom_range(span / 2, 2 * span + 3)) begin
      case ($urandom_range(0, 19))
        0:       send_cmd(ACT_SET, pick_target(), pick_target(), '0, '0);
        1:       send_noise();
        default: send_tick();
      endcase
    end
  endtask

  task automatic run_flat_start();
    logic [TgtW-1:0] a;
    logic [TgtW-1:0] b;
    a = TgtW'($urandom_range(0, FullScale));
    b = TgtW'($urandom_range(0, FullScale));
    send_cmd(ACT_SET, a, b, '0, '0);
    send_cmd(ACT_START, ($urandom_range(0, 1) == 1) ? a : pick_target(), b,
             pick_ticks(), pick_ticks());
    repeat ($urandom_range(0, 4)) send_tick();
  endtask

  initial begin
    cmd_if.valid      = 1'b0;
    cmd_if.action     = ACT_TICK;
    cmd_if.target_ch1 = '0;
    cmd_if.target_ch2 = '0;
    cmd_if.ticks_ch1  = '0;
    cmd_if.ticks_ch2  = '0;
    sts_if.ready      = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_cmd(ACT_TICK, '1, '1, '1, '1);
    send_cmd(ACT_NONE, 16'hA5A5, 16'h5A5A, 16'hFFFF, 16'h0000);
    send_cmd(ACT_SET, 16'hFFFF, 16'h1000, '0, '0);
    send_cmd(ACT_SET, TgtW'(FullScale), '0, '1, '1);
    send_cmd(ACT_START, '0, 16'hFFFF, '0, '0);
    send_tick();
    send_tick();
    send_cmd(ACT_SET, 16'd1000, 16'd1000, '0, '0);
    send_cmd(ACT_START, 16'd1000, 16'd1003, 16'd5, 16'hFFFF);
    send_tick();
    send_cmd(ACT_SET, 16'd7, 16'd4000, '0, '0);
    repeat (3) send_tick();
    send_cmd(ACT_START, '0, 16'h0FFF, 16'hFFFF, 16'd3);
    repeat (2) send_tick();
    send_cmd(ACT_NONE, '1, '1, '1, '1);
    repeat (4) send_tick();
    send_cmd(ACT_SET, 16'd500, 16'd600, '0, '0);
    send_cmd(ACT_START, 16'd500, 16'd600, 16'd7, 16'd7);
    send_tick();

    while (sent < CmdTarget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: run_ramp();
        6:                run_flat_start();
        default:          repeat ($urandom_range(1, 4)) send_noise();
      endcase
    end
    cmd_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DacBitsDef + 4) @(negedge clk_i);

    $display("Drove %0d commands: %0d ramp starts, %0d ticks, %0d direct loads, %0d unused.",
             sent, n_start, n_tick, n_set, n_none);
    $display("Compared %0d status beats; %0d channel ramps ran to their target.",
             checked, reached);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
